>>> rtl/core/slpl_pkg.sv
// Package for the stereo lookahead peak limiter core.
// Holds the sample and coefficient widths, register indexes and reset values.
// No dependencies.
package slpl_pkg;

    localparam int unsigned SAMPLE_BITS       = 24;
    localparam int unsigned COEF_BITS         = 24;
    localparam int unsigned DEF_MAX_LOOKAHEAD = 256;
    localparam int unsigned LA_BITS           = 9;
    localparam int unsigned CFG_DATA_BITS     = 24;
    localparam int unsigned CFG_INDEX_BITS    = 3;

    localparam logic [SAMPLE_BITS-1:0] UNITY = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CEILING   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOKAHEAD = 3'd4;

    localparam logic                   RST_ENABLE    = 1'b1;
    localparam logic [COEF_BITS-1:0]   RST_ATTACK    = 24'd16431300;
    localparam logic [COEF_BITS-1:0]   RST_RELEASE   = 24'd16770226;
    localparam logic [SAMPLE_BITS-1:0] RST_CEILING   = 24'd7476483;
    localparam logic [LA_BITS-1:0]     RST_LOOKAHEAD = 9'd96;

endpackage

>>> rtl/core/stereo_lookahead_peak_limiter_core.sv
// Stereo lookahead peak limiter core: envelope follower, gain smoother and delay memory.
// Depends on slpl_pkg and slpl_divider.
//
// Usage: one stereo pair enters on the input channel (i_in_valid / o_in_ready);
// one result leaves on the output channel (o_out_valid / i_out_ready); if limiting it
// carries the pair delayed by the lookahead, scaled by the smoothed gain, and that gain.
// Registers are written on the configuration channel, which is always ready; write
// them only while no item is in flight.
// Each item is worked one at a time; when limiting, through a shared multiplier and
// the delay memory in S_ENV_A, S_ENV_B, S_TGT, S_GAIN_A, S_GAIN_B, S_MUL_L, S_MUL_R
// and S_OUT, with S_DIV after S_TGT when the envelope lies above the ceiling and
// the serial divider runs one quotient bit per cycle. In bypass an item goes straight
// to S_OUT, undelayed and with unity gain. S_OUT loads the output register once free.
// After reset the delay memory is cleared one entry per cycle, all MAX_LOOKAHEAD entries,
// while no item is accepted. A stalled receiver holds the result in the output
// register; the next item is still accepted and waits for that register to free.
module stereo_lookahead_peak_limiter_core
    import slpl_pkg::*;
#(
    parameter int unsigned MAX_LOOKAHEAD = DEF_MAX_LOOKAHEAD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    output logic        [SAMPLE_BITS-1:0] o_applied_gain,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int unsigned SB  = SAMPLE_BITS;
    localparam int unsigned AW  = $clog2(MAX_LOOKAHEAD);
    localparam int unsigned LW  = (AW + 1 > LA_BITS) ? AW + 1 : LA_BITS;
    localparam int unsigned MW  = (COEF_BITS + 2 > SB + 1) ? COEF_BITS + 2 : SB + 1;
    localparam int unsigned PW  = 2 * MW;
    localparam int unsigned ACW = COEF_BITS + SB;
    localparam logic [ACW-1:0] ROUND = ACW'(1) << (COEF_BITS - 1);
    localparam logic [LW-1:0]  MAX_LEN = LW'(MAX_LOOKAHEAD);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_ENV_A  = 10'b00_0000_0010,
        S_ENV_B  = 10'b00_0000_0100,
        S_TGT    = 10'b00_0000_1000,
        S_DIV    = 10'b00_0001_0000,
        S_GAIN_A = 10'b00_0010_0000,
        S_GAIN_B = 10'b00_0100_0000,
        S_MUL_L  = 10'b00_1000_0000,
        S_MUL_R  = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    function automatic logic [SB-1:0] scale_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] smax;
        logic signed [PW-1:0] smin;
        logic signed [PW-1:0] t;
        logic signed [PW-1:0] sh;
        smax = $signed({{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}});
        smin = $signed({{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}});
        t    = p + $signed({{(PW-SB+1){1'b0}}, 1'b1, {(SB-2){1'b0}}});
        sh   = t >>> (SB - 1);
        if (sh > smax) begin
            sh = smax;
        end else if (sh < smin) begin
            sh = smin;
        end
        return sh[SB-1:0];
    endfunction

    // Configuration registers.
    logic                 r_enable;
    logic [COEF_BITS-1:0] r_attack;
    logic [COEF_BITS-1:0] r_release;
    logic [SB-1:0]        r_ceiling;
    logic [LA_BITS-1:0]   r_lookahead;

    // Control state.
    t_state               r_state;
    logic                 r_clr_busy;
    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_pos;
    logic [SB-1:0]        r_env;
    logic [SB-1:0]        r_gain;
    logic                 r_out_valid;

    // Working registers.
    logic [AW-1:0]        r_addr;
    logic [SB-1:0]        r_l;
    logic [SB-1:0]        r_r;
    logic [SB-1:0]        r_peak;
    logic [SB-1:0]        r_target;
    logic [ACW-1:0]       r_acc;
    logic [SB-1:0]        r_res_l;
    logic [SB-1:0]        r_res_r;
    logic [SB-1:0]        r_res_g;
    logic [SB-1:0]        r_out_l;
    logic [SB-1:0]        r_out_r;
    logic [SB-1:0]        r_out_g;

    // Delay memory, left sample in the upper half.
    logic [2*SB-1:0]      r_mem [MAX_LOOKAHEAD];
    logic [2*SB-1:0]      r_mem_q;

    logic                 in_acc;
    logic [SB-1:0]        ceil_lim;
    logic [LW-1:0]        la_ext;
    logic [LW-1:0]        len;
    logic [AW-1:0]        pos_use;
    logic [LW-1:0]        pos_inc;
    logic [AW-1:0]        pos_next;
    logic [SB-1:0]        mag_l;
    logic [SB-1:0]        mag_r;
    logic [COEF_BITS-1:0] c_env;
    logic [COEF_BITS-1:0] c_gain;
    logic [COEF_BITS:0]   c_cmp;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [ACW-1:0]       pole_sum;
    logic [SB-1:0]        pole_out;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [2*SB-1:0]      mem_wdata;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [SB-1:0]        div_quot;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && !r_clr_busy;
    assign in_acc      = i_in_valid && o_in_ready;

    assign ceil_lim = (r_ceiling > UNITY) ? UNITY : r_ceiling;

    assign la_ext   = LW'(r_lookahead);
    assign len      = (la_ext == '0) ? LW'(1) : ((la_ext > MAX_LEN) ? MAX_LEN : la_ext);
    assign pos_use  = (LW'(r_pos) >= len) ? '0 : r_pos;
    assign pos_inc  = LW'(pos_use) + LW'(1);
    assign pos_next = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];

    assign mag_l = i_left_in[SB-1]  ? (~i_left_in  + 1'b1) : i_left_in;
    assign mag_r = i_right_in[SB-1] ? (~i_right_in + 1'b1) : i_right_in;

    assign c_env  = (r_peak > r_env) ? r_attack : r_release;
    assign c_gain = (r_target < r_gain) ? r_attack : r_release;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        c_cmp = '0;
        case (r_state)
            S_ENV_A: begin
                mul_a = MW'(c_env);
                mul_b = MW'(r_env);
            end
            S_ENV_B: begin
                c_cmp = {1'b1, {COEF_BITS{1'b0}}} - {1'b0, c_env};
                mul_a = MW'(c_cmp);
                mul_b = MW'(r_peak);
            end
            S_GAIN_A: begin
                mul_a = MW'(c_gain);
                mul_b = MW'(r_gain);
            end
            S_GAIN_B: begin
                c_cmp = {1'b1, {COEF_BITS{1'b0}}} - {1'b0, c_gain};
                mul_a = MW'(c_cmp);
                mul_b = MW'(r_target);
            end
            S_MUL_L: begin
                mul_a = MW'($signed(r_mem_q[2*SB-1:SB]));
                mul_b = MW'(r_gain);
            end
            S_MUL_R: begin
                mul_a = MW'($signed(r_mem_q[SB-1:0]));
                mul_b = MW'(r_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign pole_sum = r_acc + prod[ACW-1:0] + ROUND;
    assign pole_out = pole_sum[ACW-1:COEF_BITS];

    assign mem_we    = r_clr_busy || (r_state == S_ENV_A);
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_addr;
    assign mem_wdata = r_clr_busy ? '0 : {r_l, r_r};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_mem_q <= r_mem[pos_use];
        end
    end

    assign div_start = (r_state == S_TGT) && (r_env > ceil_lim);
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    slpl_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (ceil_lim),
        .i_den   (r_env),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= RST_ENABLE;
            r_attack    <= RST_ATTACK;
            r_release   <= RST_RELEASE;
            r_ceiling   <= RST_CEILING;
            r_lookahead <= RST_LOOKAHEAD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE:    r_enable    <= i_cfg_data[0];
                REG_ATTACK:    r_attack    <= i_cfg_data[COEF_BITS-1:0];
                REG_RELEASE:   r_release   <= i_cfg_data[COEF_BITS-1:0];
                REG_CEILING:   r_ceiling   <= SB'(i_cfg_data);
                REG_LOOKAHEAD: r_lookahead <= i_cfg_data[LA_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_pos       <= '0;
            r_env       <= '0;
            r_gain      <= UNITY;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_LOOKAHEAD - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_enable) begin
                            r_pos   <= pos_next;
                            r_state <= S_ENV_A;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_ENV_A:  r_state <= S_ENV_B;
                S_ENV_B: begin
                    r_env   <= pole_out;
                    r_state <= S_TGT;
                end
                S_TGT:    r_state <= div_start ? S_DIV : S_GAIN_A;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_GAIN_A;
                    end
                end
                S_GAIN_A: r_state <= S_GAIN_B;
                S_GAIN_B: begin
                    r_gain  <= (pole_out > UNITY) ? UNITY : pole_out;
                    r_state <= S_MUL_L;
                end
                S_MUL_L:  r_state <= S_MUL_R;
                S_MUL_R:  r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr  <= pos_use;
            r_l     <= i_left_in;
            r_r     <= i_right_in;
            r_peak  <= (mag_l > mag_r) ? mag_l : mag_r;
            r_res_l <= i_left_in;
            r_res_r <= i_right_in;
            r_res_g <= UNITY;
        end
        if ((r_state == S_ENV_A) || (r_state == S_GAIN_A)) begin
            r_acc <= prod[ACW-1:0];
        end
        if (r_state == S_TGT) begin
            r_target <= UNITY;
        end else if ((r_state == S_DIV) && div_done) begin
            r_target <= div_quot;
        end
        if (r_state == S_MUL_L) begin
            r_res_l <= scale_sat(prod);
        end
        if (r_state == S_MUL_R) begin
            r_res_r <= scale_sat(prod);
            r_res_g <= r_gain;
        end
        if (out_load) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
            r_out_g <= r_res_g;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_out     = r_out_l;
    assign o_right_out    = r_out_r;
    assign o_applied_gain = r_out_g;

endmodule

>>> rtl/core/slpl_divider.sv
// Serial restoring divider for the target gain: quotient of numerator times unity
// over the divisor, one quotient bit per cycle. Requires numerator below divisor.
// Depends on slpl_pkg.
module slpl_divider
    import slpl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_num,
    input  logic [SAMPLE_BITS-1:0] i_den,
    output logic                   o_done,
    output logic [SAMPLE_BITS-1:0] o_quot
);

    localparam int unsigned ITER = SAMPLE_BITS - 1;
    localparam int unsigned CW   = $clog2(SAMPLE_BITS);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [ITER-1:0]        r_quot;

    logic [SAMPLE_BITS:0]   trial;
    logic                   take;
    logic [SAMPLE_BITS:0]   diff;

    assign trial = {r_rem, 1'b0};
    assign take  = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            r_quot <= {r_quot[ITER-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = {1'b0, r_quot};

endmodule

>>> test/stereo_lookahead_peak_limiter_core_test.sv
// Self-checking testbench for stereo_lookahead_peak_limiter_core.
// Drives stereo pairs and register writes with random idling and compares each output
// item with an in-bench limiter predictor; depends on slpl_pkg and the core RTL.
module stereo_lookahead_peak_limiter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slpl_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COEF_BITS-1:0]          COEF_FULL  = {COEF_BITS{1'b1}};
    localparam int unsigned                   INDEX_LAST = (1 << CFG_INDEX_BITS) - 1;

    typedef enum int unsigned {
        MIX_RANDOM,
        MIX_QUIET,
        MIX_LOUD,
        MIX_EXTREME,
        MIX_SILENT
    } t_sample_mix;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic        [SAMPLE_BITS-1:0] gain;
    } t_limited_pair;

    class t_limiter_scoreboard;
        logic [SAMPLE_BITS-1:0] delay_left [DEF_MAX_LOOKAHEAD];
        logic [SAMPLE_BITS-1:0] delay_right[DEF_MAX_LOOKAHEAD];
        int unsigned            write_pos;
        logic [SAMPLE_BITS-1:0] envelope;
        logic [SAMPLE_BITS-1:0] gain;
        logic                   enable;
        logic [COEF_BITS-1:0]   attack;
        logic [COEF_BITS-1:0]   release_c;
        logic [SAMPLE_BITS-1:0] ceiling;
        logic [LA_BITS-1:0]     lookahead;
        t_limited_pair          expected_pairs[$];
        int unsigned            errors;

        function new();
            foreach (delay_left[i]) begin
                delay_left[i]  = '0;
                delay_right[i] = '0;
            end
            write_pos = 0;
            envelope  = '0;
            gain      = UNITY;
            enable    = RST_ENABLE;
            attack    = RST_ATTACK;
            release_c = RST_RELEASE;
            ceiling   = RST_CEILING;
            lookahead = RST_LOOKAHEAD;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_ENABLE:    enable    = data[0];
                REG_ATTACK:    attack    = data[COEF_BITS-1:0];
                REG_RELEASE:   release_c = data[COEF_BITS-1:0];
                REG_CEILING:   ceiling   = data[SAMPLE_BITS-1:0];
                REG_LOOKAHEAD: lookahead = data[LA_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_BITS-1:0] smooth(logic [SAMPLE_BITS-1:0] prev,
                                                logic [SAMPLE_BITS-1:0] x,
                                                logic [COEF_BITS-1:0] c);
            longint unsigned cc;
            longint unsigned acc;
            cc  = c;
            acc = cc * prev + ((64'd1 << COEF_BITS) - cc) * x + (64'd1 << (COEF_BITS - 1));
            return SAMPLE_BITS'(acc >> COEF_BITS);
        endfunction

        function logic signed [SAMPLE_BITS-1:0] apply_gain(logic signed [SAMPLE_BITS-1:0] s,
                                                           logic [SAMPLE_BITS-1:0] g);
            longint p;
            longint q;
            p = longint'(s) * longint'({1'b0, g});
            q = (p + (64'sd1 <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
            if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
            if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
            return SAMPLE_BITS'(q);
        endfunction

        function void accept_pair(logic signed [SAMPLE_BITS-1:0] l,
                                  logic signed [SAMPLE_BITS-1:0] r);
            t_limited_pair          res;
            longint                 ml;
            longint                 mr;
            logic [SAMPLE_BITS-1:0] peak;
            logic [SAMPLE_BITS-1:0] ceil_eff;
            logic [SAMPLE_BITS-1:0] target;
            int unsigned            len;
            int unsigned            pos;
            if (!enable) begin
                res.left  = l;
                res.right = r;
                res.gain  = UNITY;
                expected_pairs.push_back(res);
                return;
            end
            ml   = longint'(l) < 0 ? -longint'(l) : longint'(l);
            mr   = longint'(r) < 0 ? -longint'(r) : longint'(r);
            peak = SAMPLE_BITS'(ml > mr ? ml : mr);
            envelope = smooth(envelope, peak, peak > envelope ? attack : release_c);
            ceil_eff = ceiling > UNITY ? UNITY : ceiling;
            target   = UNITY;
            if (envelope > ceil_eff && envelope != 0)
                target = SAMPLE_BITS'((longint'(ceil_eff) << (SAMPLE_BITS - 1))
                                      / longint'(envelope));
            gain = smooth(gain, target, target < gain ? attack : release_c);
            if (gain > UNITY) gain = UNITY;
            len = lookahead;
            if (len < 1) len = 1;
            if (len > DEF_MAX_LOOKAHEAD) len = DEF_MAX_LOOKAHEAD;
            pos = write_pos >= len ? 0 : write_pos;
            res.left         = apply_gain(delay_left[pos], gain);
            res.right        = apply_gain(delay_right[pos], gain);
            res.gain         = gain;
            delay_left[pos]  = l;
            delay_right[pos] = r;
            write_pos        = pos + 1 >= len ? 0 : pos + 1;
            expected_pairs.push_back(res);
        endfunction

        function void check_output(logic signed [SAMPLE_BITS-1:0] l,
                                   logic signed [SAMPLE_BITS-1:0] r,
                                   logic [SAMPLE_BITS-1:0] g);
            t_limited_pair want;
            if (expected_pairs.size() == 0) begin
                $error("output item with no input item pending");
                errors++;
                return;
            end
            want = expected_pairs.pop_front();
            if (l !== want.left) begin
                $error("left_out: expected %0d, actual %0d", want.left, l);
                errors++;
            end
            if (r !== want.right) begin
                $error("right_out: expected %0d, actual %0d", want.right, r);
                errors++;
            end
            if (g !== want.gain) begin
                $error("applied_gain: expected %0d, actual %0d", want.gain, g);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_left_in;
    logic signed [SAMPLE_BITS-1:0] i_right_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [SAMPLE_BITS-1:0] o_left_out;
    logic signed [SAMPLE_BITS-1:0] o_right_out;
    logic        [SAMPLE_BITS-1:0] o_applied_gain;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data;

    t_limiter_scoreboard sb;
    int unsigned         idle_odds;
    bit                  hold_request;
    int unsigned         stall_left;

    stereo_lookahead_peak_limiter_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_in      (i_left_in),
        .i_right_in     (i_right_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_applied_gain (o_applied_gain),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    task automatic send_pair(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.accept_pair(l, r);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic en, logic [COEF_BITS-1:0] att, logic [COEF_BITS-1:0] rel,
                             logic [SAMPLE_BITS-1:0] ceil_level, logic [LA_BITS-1:0] la,
                             bit unused_too);
        drain();
        write_reg(REG_ENABLE, CFG_DATA_BITS'({$urandom, en}));
        write_reg(REG_ATTACK, att);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_CEILING, ceil_level);
        write_reg(REG_LOOKAHEAD, CFG_DATA_BITS'({$urandom, la}));
        if (unused_too)
            for (int k = REG_LOOKAHEAD + 1; k <= INDEX_LAST; k++)
                write_reg(CFG_INDEX_BITS'(k), CFG_DATA_BITS'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(t_sample_mix mix);
        int v;
        case (mix)
            MIX_RANDOM: return SAMPLE_BITS'($urandom);
            MIX_QUIET: begin
                v = $urandom_range(0, 8191);
                return SAMPLE_BITS'(v - 4096);
            end
            MIX_LOUD: begin
                v = $urandom_range(6000000, 8388608);
                return SAMPLE_BITS'($urandom_range(0, 1) ? -v : v > 8388607 ? 8388607 : v);
            end
            MIX_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return SAMPLE_BITS'(1);
                    3: return SAMPLE_BITS'(-1);
                    default: return '0;
                endcase
            end
            default: return '0;
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_coeff();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return COEF_FULL;
            2: return COEF_BITS'($urandom);
            default: return COEF_BITS'($urandom_range(16000000, 16777215));
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_ceiling();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return UNITY;
            2: return SAMPLE_BITS'($urandom_range(UNITY + 1, COEF_FULL));
            3: return SAMPLE_BITS'($urandom_range(0, UNITY));
            default: return SAMPLE_BITS'($urandom_range(2000000, UNITY));
        endcase
    endfunction

    function automatic logic [LA_BITS-1:0] pick_lookahead();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return LA_BITS'(1);
            2: return LA_BITS'(DEF_MAX_LOOKAHEAD);
            3: return LA_BITS'($urandom_range(DEF_MAX_LOOKAHEAD + 1, (1 << LA_BITS) - 1));
            4: return LA_BITS'($urandom_range(2, 8));
            default: return LA_BITS'($urandom_range(1, DEF_MAX_LOOKAHEAD));
        endcase
    endfunction

    task automatic run_random(int unsigned count);
        t_sample_mix mix;
        t_sample_mix mix_r;
        int unsigned burst;
        burst = 0;
        mix   = MIX_RANDOM;
        for (int unsigned n = 0; n < count; n++) begin
            if (burst == 0) begin
                mix   = t_sample_mix'($urandom_range(MIX_RANDOM, MIX_SILENT));
                burst = $urandom_range(4, 40);
            end
            burst--;
            mix_r = $urandom_range(0, 3) == 0 ?
                    t_sample_mix'($urandom_range(MIX_RANDOM, MIX_SILENT)) : mix;
            send_pair(pick_sample(mix), pick_sample(mix_r));
        end
        stop_sending();
    endtask

    initial begin
        i_out_ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_output(o_left_out, o_right_out, o_applied_gain);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = 500;
            end else if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        sb = new();
        hold_request = 1'b0;
        idle_odds    = 4;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_left_in   <= '0;
        i_right_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_ENABLE;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pair('0, '0);
        send_pair(SAMPLE_MAX, '0);
        send_pair('0, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(-1));
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        stop_sending();

        // Instant attack, zero ceiling, lookahead of zero acting as one.
        configure(1'b1, '0, COEF_FULL, '0, '0, 1'b0);
        send_pair('0, '0);
        send_pair(SAMPLE_MIN, '0);
        send_pair(SAMPLE_MAX, SAMPLE_BITS'(-5));
        send_pair(SAMPLE_BITS'(3), SAMPLE_BITS'(-3));
        send_pair('0, '0);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        stop_sending();

        // Ceiling above unity and lookahead above the maximum.
        configure(1'b1, COEF_FULL, '0, COEF_FULL, LA_BITS'((1 << LA_BITS) - 1), 1'b0);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(SAMPLE_BITS'(-1), SAMPLE_BITS'(1));
        send_pair('0, SAMPLE_MAX);
        stop_sending();

        // Bypass, with writes to the unused register indexes.
        configure(1'b0, RST_ATTACK, RST_RELEASE, RST_CEILING, RST_LOOKAHEAD, 1'b1);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair('0, SAMPLE_BITS'(-1));
        stop_sending();

        for (int unsigned ph = 0; ph < 14; ph++) begin
            if (ph == 1)
                configure(1'b1, '0, pick_coeff(), pick_ceiling(), LA_BITS'(DEF_MAX_LOOKAHEAD),
                          1'b0);
            else if (ph == 2)
                configure(1'b1, pick_coeff(), pick_coeff(), pick_ceiling(), LA_BITS'(3), 1'b0);
            else
                configure($urandom_range(0, 5) != 0, pick_coeff(), pick_coeff(), pick_ceiling(),
                          pick_lookahead(), $urandom_range(0, 2) == 0);
            idle_odds = ph >= 12 ? 0 : ($urandom_range(0, 4) == 0 ? 0 :
                                        $urandom_range(0, 1) ? 3 : 6);
            if (ph == 5 || ph == 9)
                hold_request = 1'b1;
            run_random(115);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/core/slpl_pkg.sv
rtl/core/slpl_divider.sv
rtl/core/stereo_lookahead_peak_limiter_core.sv
test/stereo_lookahead_peak_limiter_core_test.sv
